>>> hw/rtl/hsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsd_pkg
// shared types and codes of the huffman stream decoder
// ----------------------------------------------------------------------------
package hsd_pkg;

    // control sequencer of the core
    typedef enum logic [2:0] {
        S_IDLE,
        S_TREE,
        S_POP,
        S_WALK,
        S_END,
        S_ERR
    } t_state;

    // where the current file stands
    typedef enum logic [2:0] {
        PH_HEAD_A,
        PH_HEAD_B,
        PH_TREE,
        PH_DATA,
        PH_DRAIN
    } t_phase;

    localparam logic [7:0] CHAR_INNER  = 8'h2A;
    localparam logic [7:0] CHAR_ESCAPE = 8'h5C;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
    localparam logic [1:0] ERR_LENGTH    = 2'd2;
    localparam logic [1:0] ERR_MALFORMED = 2'd3;

endpackage : hsd_pkg
`default_nettype wire

>>> hw/rtl/huffman_stream_decoder_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// huffman_stream_decoder_core
// decodes a huffman-compressed file with a preorder tree header, one word in,
// one decoded byte per result word out
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------------
//  in      | input     | i_in_valid / o_in_stall   | i_in_byte, i_last_byte
//  out     | output    | o_out_valid / i_out_stall | o_symbol, o_has_symbol, o_run_end,
//          |           |                           | o_stream_end, o_error_code
//
//  header word: accepted in S_IDLE; tree word: S_IDLE, then S_TREE, then S_POP when a
//  child slot is popped or S_END when the final word closes the tree and its closing
//  result goes out; data word: S_IDLE accept, then S_WALK for each data bit (8,
//  fewer on the final word by the padding count), then S_END for the closing result;
//  a decoded byte whose result register is still stalled holds the bit walk, since
//  each bit needs one read of the child table and that read sets the address of the next
//  reset is synchronous and clears all control state; the tables need no clearing pass
//  an error result goes out from S_ERR; closing and error results wait while the
//  result register is stalled; o_in_stall is high whenever a word is in work
//
module huffman_stream_decoder_core
    import hsd_pkg::*;
#(
    parameter int MAX_NODES   = 512,
    parameter int STACK_DEPTH = 256
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // input words
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_last_byte,
    // result words
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_symbol,
    output logic            o_has_symbol,
    output logic            o_run_end,
    output logic            o_stream_end,
    output logic [1:0]      o_error_code
);

    // node index, node count, slot (node and side), stack address and pointer widths
    localparam int NW  = $clog2(MAX_NODES);
    localparam int CW  = $clog2(MAX_NODES + 1);
    localparam int LW  = NW + 1;
    localparam int SA  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SW  = $clog2(STACK_DEPTH + 1);
    localparam int CHW = NW + 9;

    // one child slot of the tree: the node it points at, with that node's leaf
    // flag and symbol kept alongside so that a walk step needs a single read
    typedef struct packed {
        logic [NW-1:0] idx;
        logic          leaf;
        logic [7:0]    sym;
    } t_child;

    // ------------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------------
    t_state        r_state, n_state;
    t_phase        r_phase, n_phase;
    logic [7:0]    r_byte;
    logic          r_last;
    logic [CW-1:0] r_node_cnt, n_node_cnt;
    logic [SW-1:0] r_sp, n_sp;
    logic [LW-1:0] r_open_slot, n_open_slot;
    logic          r_esc, n_esc;
    logic [NW-1:0] r_walk, n_walk;
    logic [2:0]    r_pad, n_pad;
    logic [12:0]   r_tlen, n_tlen;
    logic [12:0]   r_seen, n_seen;
    logic          r_root_leaf, n_root_leaf;
    logic [7:0]    r_shift, n_shift;     // data word, msb is the bit being walked
    logic [3:0]    r_bits, n_bits;       // data bits still to walk
    logic          r_pend_valid, n_pend_valid;
    logic [7:0]    r_pend_sym, n_pend_sym;
    logic [1:0]    r_err, n_err;

    // result register
    logic          r_out_valid;
    logic [7:0]    r_symbol;
    logic          r_has_symbol;
    logic          r_run_end;
    logic          r_stream_end;
    logic [1:0]    r_error_code;

    // ------------------------------------------------------------------------
    // combinational
    // ------------------------------------------------------------------------
    logic          in_acc;
    logic          out_free;
    logic          push;
    logic [7:0]    p_sym;
    logic          p_has;
    logic          p_run;
    logic          p_stream;
    logic [1:0]    p_code;
    logic          new_file;

    // tree word decode
    logic          is_esc;
    logic          is_inner;
    logic [12:0]   seen_inc;
    logic [12:0]   chk_seen;
    logic          tb_full;
    logic          st_full;
    logic          new_root_leaf;
    logic          tree_err1;
    logic          tree_pop;
    logic          tree_done;
    logic          tree_fail;
    logic [1:0]    tree_code;
    logic          open_fail;
    logic [1:0]    open_code;

    // walk
    t_child        ch_rd;
    logic          w_go;
    logic [NW-1:0] w_next;
    logic          end_err;
    logic          end_done;

    // memories
    logic           ch_we;
    logic [LW-1:0]  ch_waddr;
    t_child         ch_wd;
    logic [LW-1:0]  ch_raddr;
    logic [CHW-1:0] ch_rdata;
    logic           st_we;
    logic [SA-1:0]  st_waddr;
    logic [LW-1:0]  st_wdata;
    logic [SA-1:0]  st_raddr;
    logic [LW-1:0]  st_rdata;

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_symbol     = r_symbol;
    assign o_has_symbol = r_has_symbol;
    assign o_run_end    = r_run_end;
    assign o_stream_end = r_stream_end;
    assign o_error_code = r_error_code;

    // ------------------------------------------------------------------------
    // child table: slot address is {parent node, side}, 2 * MAX_NODES slots
    // ------------------------------------------------------------------------
    hsd_ram #(
        .WIDTH (CHW),
        .DEPTH (2 * MAX_NODES)
    ) u_child_ram (
        .i_clk   (i_clk),
        .i_we    (ch_we),
        .i_waddr (ch_waddr),
        .i_wdata (ch_wd),
        .i_raddr (ch_raddr),
        .o_rdata (ch_rdata)
    );

    assign ch_rd = t_child'(ch_rdata);

    // stack of child slots still waiting for their subtree
    hsd_ram #(
        .WIDTH (LW),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    // ------------------------------------------------------------------------
    // tree word decode, used in S_TREE and S_POP
    // ------------------------------------------------------------------------
    assign is_esc        = !r_esc && (r_byte == CHAR_ESCAPE);
    assign is_inner      = !r_esc && (r_byte == CHAR_INNER);
    assign seen_inc      = r_seen + 13'd1;
    assign chk_seen      = (r_state == S_POP) ? r_seen : seen_inc;
    assign tb_full       = (r_node_cnt >= CW'(MAX_NODES));
    assign st_full       = (r_sp >= SW'(STACK_DEPTH));
    assign new_root_leaf = (r_node_cnt == '0) ? !is_inner : r_root_leaf;

    assign tree_err1 = !is_esc && (tb_full || (is_inner && st_full));
    assign tree_pop  = !is_esc && !tree_err1 && !is_inner && (r_sp != '0);
    assign tree_done = !is_esc && !tree_err1 && !is_inner && (r_sp == '0);

    // checks while the tree is still open: count used up, or file ended early
    always_comb begin
        open_fail = 1'b0;
        open_code = ERR_NONE;
        if (chk_seen >= r_tlen) begin
            open_fail = 1'b1;
            open_code = ERR_LENGTH;
        end else if (r_last) begin
            open_fail = 1'b1;
            open_code = ERR_MALFORMED;
        end
    end

    always_comb begin
        tree_fail = 1'b0;
        tree_code = ERR_NONE;
        if (tree_err1) begin
            tree_fail = 1'b1;
            tree_code = ERR_OVERFLOW;
        end else if (tree_done) begin
            // tree closed: length has to match and the root has to be inner
            if (seen_inc != r_tlen) begin
                tree_fail = 1'b1;
                tree_code = ERR_LENGTH;
            end else if (new_root_leaf) begin
                tree_fail = 1'b1;
                tree_code = ERR_MALFORMED;
            end
        end else if (!tree_pop) begin
            tree_fail = open_fail;
            tree_code = open_code;
        end
    end

    // ------------------------------------------------------------------------
    // walk step: the child read for the current bit sits in ch_rd
    // a leaf is held back one step so the last one of a word can carry run_end
    // ------------------------------------------------------------------------
    assign w_go     = !ch_rd.leaf || !r_pend_valid || out_free;
    assign w_next   = ch_rd.leaf ? '0 : ch_rd.idx;
    assign end_err  = r_last && (r_walk != '0);
    assign end_done = out_free && !(r_pend_valid && end_err);

    // ------------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (r_phase)
                        PH_HEAD_A, PH_HEAD_B: n_state = i_last_byte ? S_ERR : S_IDLE;
                        PH_TREE:              n_state = S_TREE;
                        PH_DATA:              n_state = S_WALK;
                        default:              n_state = S_IDLE;
                    endcase
                end
            end
            S_TREE: begin
                if (tree_fail) begin
                    n_state = S_ERR;
                end else if (tree_pop) begin
                    n_state = S_POP;
                end else if (tree_done && r_last) begin
                    n_state = S_END;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_POP: begin
                n_state = open_fail ? S_ERR : S_IDLE;
            end
            S_WALK: begin
                if (w_go && (r_bits == 4'd1)) begin
                    n_state = S_END;
                end
            end
            S_END: begin
                if (end_done) begin
                    n_state = S_IDLE;
                end
            end
            S_ERR: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------------
    // outputs, memory ports and datapath next values
    // ------------------------------------------------------------------------
    always_comb begin
        push         = 1'b0;
        p_sym        = '0;
        p_has        = 1'b0;
        p_run        = 1'b0;
        p_stream     = 1'b0;
        p_code       = ERR_NONE;
        new_file     = 1'b0;

        ch_we        = 1'b0;
        ch_waddr     = r_open_slot;
        ch_wd.idx    = r_node_cnt[NW-1:0];
        ch_wd.leaf   = !is_inner;
        ch_wd.sym    = r_byte;
        ch_raddr     = {r_walk, r_shift[7]};
        st_we        = 1'b0;
        st_waddr     = r_sp[SA-1:0];
        st_wdata     = {r_node_cnt[NW-1:0], 1'b1};
        st_raddr     = SA'(r_sp - SW'(1));

        n_phase      = r_phase;
        n_node_cnt   = r_node_cnt;
        n_sp         = r_sp;
        n_open_slot  = r_open_slot;
        n_esc        = r_esc;
        n_walk       = r_walk;
        n_pad        = r_pad;
        n_tlen       = r_tlen;
        n_seen       = r_seen;
        n_root_leaf  = r_root_leaf;
        n_shift      = r_shift;
        n_bits       = r_bits;
        n_pend_valid = r_pend_valid;
        n_pend_sym   = r_pend_sym;
        n_err        = r_err;

        case (r_state)
            S_IDLE: begin
                // first walk read goes out with the accept
                ch_raddr = {r_walk, i_in_byte[7]};
                if (in_acc) begin
                    case (r_phase)
                        PH_HEAD_A: begin
                            n_pad         = i_in_byte[7:5];
                            n_tlen[12:8]  = i_in_byte[4:0];
                            n_phase       = PH_HEAD_B;
                            n_err         = ERR_MALFORMED;
                        end
                        PH_HEAD_B: begin
                            n_tlen[7:0]   = i_in_byte;
                            n_phase       = PH_TREE;
                            n_err         = ERR_MALFORMED;
                        end
                        PH_DATA: begin
                            n_shift = i_in_byte;
                            n_bits  = i_last_byte ? (4'd8 - {1'b0, r_pad}) : 4'd8;
                        end
                        PH_DRAIN: begin
                            new_file = i_last_byte;
                        end
                        default: ;
                    endcase
                end
            end
            S_TREE: begin
                n_seen = seen_inc;
                n_err  = tree_code;
                if (is_esc) begin
                    n_esc = 1'b1;
                end else if (!tree_err1) begin
                    n_esc       = 1'b0;
                    n_node_cnt  = r_node_cnt + CW'(1);
                    n_root_leaf = new_root_leaf;
                    // hook the new node into its parent's open slot
                    ch_we = (r_node_cnt != '0);
                    if (is_inner) begin
                        st_we       = 1'b1;
                        n_sp        = r_sp + SW'(1);
                        n_open_slot = {r_node_cnt[NW-1:0], 1'b0};
                    end else if (tree_pop) begin
                        n_sp = r_sp - SW'(1);
                    end else if (!tree_fail) begin
                        n_phase = PH_DATA;
                        n_walk  = '0;
                    end
                end
            end
            S_POP: begin
                n_open_slot = st_rdata;
                n_err       = open_code;
            end
            S_WALK: begin
                if (w_go) begin
                    ch_raddr = {w_next, r_shift[6]};
                    n_walk   = w_next;
                    n_shift  = {r_shift[6:0], 1'b0};
                    n_bits   = r_bits - 4'd1;
                    if (ch_rd.leaf) begin
                        push         = r_pend_valid;
                        p_sym        = r_pend_sym;
                        p_has        = 1'b1;
                        n_pend_valid = 1'b1;
                        n_pend_sym   = ch_rd.sym;
                    end
                end
            end
            S_END: begin
                if (out_free) begin
                    push = 1'b1;
                    if (r_pend_valid) begin
                        // held symbol closes the word unless a trailing code follows
                        p_sym        = r_pend_sym;
                        p_has        = 1'b1;
                        p_run        = !end_err;
                        p_stream     = r_last && !end_err;
                        n_pend_valid = 1'b0;
                    end else if (end_err) begin
                        p_run    = 1'b1;
                        p_stream = 1'b1;
                        p_code   = ERR_MALFORMED;
                    end else begin
                        p_run    = 1'b1;
                        p_stream = r_last;
                    end
                    new_file = end_done && r_last;
                end
            end
            S_ERR: begin
                if (out_free) begin
                    push     = 1'b1;
                    p_run    = 1'b1;
                    p_stream = 1'b1;
                    p_code   = r_err;
                    new_file = r_last;
                    n_phase  = PH_DRAIN;
                end
            end
            default: ;
        endcase

        // end of file: everything back to the state of a fresh file
        if (new_file) begin
            n_phase      = PH_HEAD_A;
            n_node_cnt   = '0;
            n_sp         = '0;
            n_open_slot  = '0;
            n_esc        = 1'b0;
            n_walk       = '0;
            n_pad        = '0;
            n_tlen       = '0;
            n_seen       = '0;
            n_root_leaf  = 1'b0;
            n_pend_valid = 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_phase      <= PH_HEAD_A;
            r_node_cnt   <= '0;
            r_sp         <= '0;
            r_open_slot  <= '0;
            r_esc        <= 1'b0;
            r_walk       <= '0;
            r_pad        <= '0;
            r_tlen       <= '0;
            r_seen       <= '0;
            r_root_leaf  <= 1'b0;
            r_bits       <= '0;
            r_pend_valid <= 1'b0;
            r_err        <= ERR_NONE;
            r_last       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_phase      <= n_phase;
            r_node_cnt   <= n_node_cnt;
            r_sp         <= n_sp;
            r_open_slot  <= n_open_slot;
            r_esc        <= n_esc;
            r_walk       <= n_walk;
            r_pad        <= n_pad;
            r_tlen       <= n_tlen;
            r_seen       <= n_seen;
            r_root_leaf  <= n_root_leaf;
            r_bits       <= n_bits;
            r_pend_valid <= n_pend_valid;
            r_err        <= n_err;
            if (in_acc) begin
                r_last <= i_last_byte;
            end
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_byte <= i_in_byte;
        end
        r_shift    <= n_shift;
        r_pend_sym <= n_pend_sym;
        if (push) begin
            r_symbol     <= p_sym;
            r_has_symbol <= p_has;
            r_run_end    <= p_run;
            r_stream_end <= p_stream;
            r_error_code <= p_code;
        end
    end

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    // a result word is never written over one that is still stalled
    a_no_overwrite : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> out_free)
        else $error("result register overwritten while stalled");

    // a held symbol only exists while data words are decoded
    a_pend_in_data : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> (r_phase == PH_DATA))
        else $error("held symbol outside the data phase");

    // every stacked slot belongs to an inner node already placed
    a_stack_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CW + SW)'(r_sp) <= (CW + SW)'(r_node_cnt))
        else $error("hole stack deeper than the node count");

    // an accepted data word starts a walk with at least one bit
    a_walk_start : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (r_phase == PH_DATA)) |=> ((r_state == S_WALK) && (r_bits != 4'd0)))
        else $error("data word did not start a walk");

    // a finished walk has no bits left
    a_walk_end : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_WALK) && (n_state == S_END)) |=> (r_bits == 4'd0))
        else $error("walk left with bits outstanding");

endmodule : huffman_stream_decoder_core
`default_nettype wire

>>> hw/rtl/hsd_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsd_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module hsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule : hsd_ram
`default_nettype wire

>>> tb/huffman_stream_decoder_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_stream_decoder_core_test
// self-checking bench for the huffman stream decoder: compressed files are fed
// word by word with random gaps and output stalls, a predictor rebuilds each
// tree and walks the data bits, and every result word is checked in order
// ----------------------------------------------------------------------------
module huffman_stream_decoder_core_test;
    import hsd_pkg::*;

    // table sizes of the instance (block defaults)
    localparam int NODE_LIMIT  = 512;
    localparam int STACK_LIMIT = 256;
    // generous ceiling: ~150 words at most, each with gaps, 8 results and stalls
    localparam int CYCLE_LIMIT = 40000;
    // cycles left for stray results once nothing is expected
    localparam int TAIL_CYCLES = 40;

    typedef logic [7:0] t_octet;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_in_word;

    typedef struct packed {
        logic [7:0] symbol;
        logic       has_symbol;
        logic       run_end;
        logic       stream_end;
        logic [1:0] error_code;
    } t_result;

    // ways of spoiling a random file
    typedef enum int {
        FLAW_NONE,
        FLAW_LENGTH,
        FLAW_TRUNCATED,
        FLAW_NOISE
    } t_flaw;

    // ------------------------------------------------------------------
    // clock, reset and block ports
    // ------------------------------------------------------------------
    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic [7:0] i_in_byte   = 8'h00;
    logic       i_last_byte = 1'b0;
    logic       i_out_stall = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [7:0] o_symbol;
    logic       o_has_symbol;
    logic       o_run_end;
    logic       o_stream_end;
    logic [1:0] o_error_code;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    huffman_stream_decoder_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_byte    (i_in_byte),
        .i_last_byte  (i_last_byte),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_symbol     (o_symbol),
        .o_has_symbol (o_has_symbol),
        .o_run_end    (o_run_end),
        .o_stream_end (o_stream_end),
        .o_error_code (o_error_code)
    );

    // ------------------------------------------------------------------
    // stimulus and scoreboard storage
    // ------------------------------------------------------------------
    t_in_word file_words[$];      // words still to be sent, in file order
    t_result  decoded_words[$];   // result words the decoder owes us
    t_octet   tree_bytes[$];      // scratch: tree section of the file being built
    t_octet   data_bytes[$];      // scratch: data section of the file being built

    // handshake flags seen at the last rising edge
    logic word_taken   = 1'b0;
    logic result_taken = 1'b0;

    // idling on each side, switched on and off in stretches
    int   in_gap       = 0;
    int   stall_left   = 0;
    logic in_idle_on   = 1'b1;
    logic out_idle_on  = 1'b1;
    t_in_word next_word;

    // run statistics
    int cycle_count    = 0;
    int mismatches     = 0;
    int words_accepted = 0;
    int symbols_out    = 0;
    int files_closed   = 0;
    int faults_seen    = 0;

    t_result got_word;
    t_result want_word;

    // ------------------------------------------------------------------
    // predictor state: one decoder file context plus its tables
    // ------------------------------------------------------------------
    t_phase     file_phase;
    logic       node_leaf [0:NODE_LIMIT-1];
    logic [7:0] node_sym  [0:NODE_LIMIT-1];
    logic [8:0] node_kid  [0:NODE_LIMIT-1][0:1];
    logic [9:0] slot_stack[0:STACK_LIMIT-1];
    logic [9:0] node_total;
    logic [8:0] stack_top;
    logic [9:0] open_slot;      // node*2 + side, side 1 is the right child
    logic       escape_armed;
    logic [8:0] walk_node;
    logic [2:0] pad_bits;
    logic [12:0] tree_len_hdr;
    logic [12:0] tree_len_got;

    function automatic t_result result_word(input logic [7:0] sym, input logic has,
                                            input logic run, input logic fin,
                                            input logic [1:0] code);
        t_result r;
        r.symbol     = sym;
        r.has_symbol = has;
        r.run_end    = run;
        r.stream_end = fin;
        r.error_code = code;
        return r;
    endfunction

    // back to the start of a file; tables keep their contents
    task automatic restart_file();
        file_phase   = PH_HEAD_A;
        node_total   = '0;
        stack_top    = '0;
        open_slot    = '0;
        escape_armed = 1'b0;
        walk_node    = '0;
        pad_bits     = '0;
        tree_len_hdr = '0;
        tree_len_got = '0;
    endtask

    // an error closes the file, or parks the decoder until the final word
    task automatic report_fault(input logic [1:0] code, input logic last);
        decoded_words.push_back(result_word(8'h00, 1'b0, 1'b1, 1'b1, code));
        if (last)
            restart_file();
        else
            file_phase = PH_DRAIN;
    endtask

    // works out the result words that one accepted input word causes
    task automatic decode_word(input logic [7:0] b, input logic last);
        logic       inner;
        logic       closed;
        logic       fault;
        logic [8:0] idx;
        int         lowest;
        int         k;
        int         i;
        t_result    held;
        closed = 1'b0;
        fault  = 1'b0;
        k      = 0;
        held   = '0;
        case (file_phase)
            PH_HEAD_A: begin
                pad_bits     = b[7:5];
                tree_len_hdr = {b[4:0], 8'h00};
                file_phase   = PH_HEAD_B;
                if (last)
                    report_fault(ERR_MALFORMED, 1'b1);
            end
            PH_HEAD_B: begin
                tree_len_hdr[7:0] = b;
                file_phase        = PH_TREE;
                if (last)
                    report_fault(ERR_MALFORMED, 1'b1);
            end
            PH_TREE: begin
                tree_len_got = tree_len_got + 1'b1;
                if (!escape_armed && b == CHAR_ESCAPE) begin
                    escape_armed = 1'b1;
                end else begin
                    inner        = !escape_armed && b == CHAR_INNER;
                    escape_armed = 1'b0;
                    if (node_total >= NODE_LIMIT || (inner && stack_top >= STACK_LIMIT)) begin
                        report_fault(ERR_OVERFLOW, last);
                        fault = 1'b1;
                    end else begin
                        idx            = node_total[8:0];
                        node_total     = node_total + 1'b1;
                        node_leaf[idx] = !inner;
                        node_sym[idx]  = b;
                        node_kid[idx][0] = '0;
                        node_kid[idx][1] = '0;
                        // hook the new node into the slot that was waiting for it
                        if (idx != 0)
                            node_kid[open_slot[9:1]][open_slot[0]] = idx;
                        if (inner) begin
                            slot_stack[stack_top] = {idx, 1'b1};
                            stack_top = stack_top + 1'b1;
                            open_slot = {idx, 1'b0};
                        end else if (stack_top != 0) begin
                            stack_top = stack_top - 1'b1;
                            open_slot = slot_stack[stack_top];
                        end else begin
                            closed = 1'b1;
                        end
                    end
                end
                if (fault) begin
                    // already reported
                end else if (closed) begin
                    if (tree_len_got != tree_len_hdr) begin
                        report_fault(ERR_LENGTH, last);
                    end else if (node_leaf[0]) begin
                        report_fault(ERR_MALFORMED, last);
                    end else begin
                        file_phase = PH_DATA;
                        walk_node  = '0;
                        if (last) begin
                            decoded_words.push_back(
                                result_word(8'h00, 1'b0, 1'b1, 1'b1, ERR_NONE));
                            restart_file();
                        end
                    end
                end else if (tree_len_got >= tree_len_hdr) begin
                    report_fault(ERR_LENGTH, last);
                end else if (last) begin
                    report_fault(ERR_MALFORMED, 1'b1);
                end
            end
            PH_DATA: begin
                lowest = last ? int'(pad_bits) : 0;
                // msb first; each leaf is held back so that the closing flags
                // can still be set on the last one
                for (i = 7; i >= lowest; i--) begin
                    walk_node = node_kid[walk_node][b[i]];
                    if (node_leaf[walk_node]) begin
                        if (k > 0)
                            decoded_words.push_back(held);
                        held = result_word(node_sym[walk_node], 1'b1, 1'b0, 1'b0, ERR_NONE);
                        k++;
                        walk_node = '0;
                    end
                end
                if (last && walk_node != 0) begin
                    if (k > 0)
                        decoded_words.push_back(held);
                    report_fault(ERR_MALFORMED, 1'b1);
                end else begin
                    if (k == 0) begin
                        held = result_word(8'h00, 1'b0, 1'b1, last, ERR_NONE);
                    end else begin
                        held.run_end    = 1'b1;
                        held.stream_end = last;
                    end
                    decoded_words.push_back(held);
                    if (last)
                        restart_file();
                end
            end
            default: begin
                // draining after an error: silent until the final word
                if (last)
                    restart_file();
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // file builders
    // ------------------------------------------------------------------
    task automatic queue_word(input t_octet data, input logic last);
        t_in_word w;
        w.data = data;
        w.last = last;
        file_words.push_back(w);
    endtask

    // header, tree_bytes, data_bytes; the final word of the lot closes the file
    task automatic queue_file(input logic [2:0] pad, input logic [12:0] len);
        t_octet whole[$];
        int     n;
        whole.push_back({pad, len[12:8]});
        whole.push_back(len[7:0]);
        foreach (tree_bytes[j])
            whole.push_back(tree_bytes[j]);
        foreach (data_bytes[j])
            whole.push_back(data_bytes[j]);
        n = whole.size();
        foreach (whole[j])
            queue_word(whole[j], j == n - 1);
    endtask

    // random full binary tree in preorder with the given number of leaves
    task automatic build_random_tree(input int leaves);
        int     inners_left;
        int     open_slots;
        t_octet sym;
        tree_bytes.delete();
        inners_left = leaves - 1;
        open_slots  = 1;
        while (open_slots > 0) begin
            // one open slot left with inner nodes to place: it must be an inner node
            if (inners_left > 0 && (open_slots == 1 || $urandom_range(0, 1) == 1)) begin
                tree_bytes.push_back(CHAR_INNER);
                inners_left--;
                open_slots++;
            end else begin
                case ($urandom_range(0, 7))
                    0:       sym = CHAR_INNER;
                    1:       sym = CHAR_ESCAPE;
                    default: sym = t_octet'($urandom_range(0, 255));
                endcase
                // the special characters need an escape, plain ones get one now and then
                if (sym == CHAR_INNER || sym == CHAR_ESCAPE || $urandom_range(0, 15) == 0)
                    tree_bytes.push_back(CHAR_ESCAPE);
                tree_bytes.push_back(sym);
                open_slots--;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // input driver: changes on the falling edge, holds a word until taken
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || word_taken)) begin
            if (in_gap > 0) begin
                in_gap--;
                i_in_valid <= 1'b0;
            end else if (file_words.size() > 0) begin
                next_word = file_words.pop_front();
                i_in_byte   <= next_word.data;
                i_last_byte <= next_word.last;
                i_in_valid  <= 1'b1;
                // idle in stretches, with quiet spells between them
                if ($urandom_range(0, 19) == 0)
                    in_idle_on = !in_idle_on;
                in_gap = in_idle_on ? $urandom_range(0, 6) : 0;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // output back-pressure: a fresh stall count per result word, spent only
    // while a result is on offer
    always @(negedge i_clk) begin
        if (result_taken) begin
            if ($urandom_range(0, 19) == 0)
                out_idle_on = !out_idle_on;
            stall_left = out_idle_on ? $urandom_range(0, 6) : 0;
        end
        i_out_stall <= (stall_left > 0);
        if (stall_left > 0 && o_out_valid)
            stall_left--;
    end

    // ------------------------------------------------------------------
    // monitor: predicts on each accepted word, checks each accepted result
    // ------------------------------------------------------------------
    task automatic check_field(input string what, input logic [7:0] want_v,
                               input logic [7:0] got_v);
        if (got_v !== want_v) begin
            mismatches++;
            $display("%0t ns: %s expected %0h got %0h", $time, what, want_v, got_v);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            word_taken   <= 1'b0;
            result_taken <= 1'b0;
        end else begin
            word_taken   <= i_in_valid && !o_in_stall;
            result_taken <= o_out_valid && !i_out_stall;
            if (i_in_valid && !o_in_stall) begin
                decode_word(i_in_byte, i_last_byte);
                words_accepted++;
            end
            if (o_out_valid && !i_out_stall) begin
                got_word = result_word(o_symbol, o_has_symbol, o_run_end,
                                       o_stream_end, o_error_code);
                if (decoded_words.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: result word expected none got %0h", $time, got_word);
                end else begin
                    want_word = decoded_words.pop_front();
                    check_field("symbol", want_word.symbol, got_word.symbol);
                    check_field("has_symbol", want_word.has_symbol, got_word.has_symbol);
                    check_field("run_end", want_word.run_end, got_word.run_end);
                    check_field("stream_end", want_word.stream_end, got_word.stream_end);
                    check_field("error_code", want_word.error_code, got_word.error_code);
                end
                if (got_word.has_symbol)
                    symbols_out++;
                if (got_word.stream_end)
                    files_closed++;
                if (got_word.error_code != ERR_NONE)
                    faults_seen++;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, decoded_words.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin : sequence_main
        int     random_words;
        int     leaves;
        int     n;
        t_flaw  flaw;
        logic [2:0]  pad;
        logic [12:0] len;

        restart_file();

        // --- directed files ---
        // '*' on code 0, '\' on 10, 'x' on 11; both special leaves escaped
        tree_bytes = '{CHAR_INNER, CHAR_ESCAPE, CHAR_INNER, CHAR_INNER,
                       CHAR_ESCAPE, CHAR_ESCAPE, 8'h78};
        // all zeros gives a full run of eight symbols; the final word drops 3 pad bits
        data_bytes = '{8'h00, 8'hFF, 8'hB0};
        queue_file(3'd3, 13'd7);

        // file cut short inside the first and inside the second header word
        queue_word(8'hFF, 1'b1);
        queue_word(8'h00, 1'b0);
        queue_word(8'hFF, 1'b1);

        // file cut short inside an unfinished tree
        tree_bytes = '{CHAR_INNER, 8'h61};
        data_bytes.delete();
        queue_file(3'd0, 13'd5);

        // root is a leaf: error, then the rest of the file is ignored
        tree_bytes = '{8'h71};
        data_bytes = '{8'h55, 8'hAA};
        queue_file(3'd0, 13'd1);

        // tree closes before the length in the header
        tree_bytes = '{CHAR_INNER, 8'h61, 8'h62};
        data_bytes = '{8'h0F};
        queue_file(3'd0, 13'd9);

        // header length used up while the tree is still open
        tree_bytes = '{CHAR_INNER, 8'h61};
        data_bytes = '{8'h33};
        queue_file(3'd0, 13'd2);

        // file ends right after its tree
        tree_bytes = '{CHAR_INNER, 8'h61, 8'h62};
        data_bytes.delete();
        queue_file(3'd5, 13'd3);

        // escaped plain leaf; final word leaves the walk inside a code
        tree_bytes = '{CHAR_INNER, CHAR_ESCAPE, 8'h41, CHAR_INNER, 8'h42, 8'h43};
        data_bytes = '{8'h01};
        queue_file(3'd0, 13'd6);

        // right spine ten deep: a word of ones decodes to nothing
        tree_bytes.delete();
        for (int j = 0; j < 9; j++) begin
            tree_bytes.push_back(CHAR_INNER);
            tree_bytes.push_back(t_octet'(8'h61 + j));
        end
        tree_bytes.push_back(8'h7A);
        data_bytes = '{8'hFF, 8'hFF, 8'h3F, 8'h00};
        queue_file(3'd0, 13'(tree_bytes.size()));

        // --- random files: mostly well formed, some spoilt ---
        random_words = 0;
        while (random_words < 36) begin
            n    = $urandom_range(0, 9);
            flaw = (n < 7) ? FLAW_NONE : t_flaw'(n - 6);
            leaves = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 14)
                                                 : $urandom_range(2, 8);
            build_random_tree(leaves);
            data_bytes.delete();
            repeat ($urandom_range(1, 5))
                data_bytes.push_back(t_octet'($urandom_range(0, 255)));
            pad = 3'($urandom_range(0, 7));
            len = 13'(tree_bytes.size());
            case (flaw)
                FLAW_LENGTH: begin
                    len = ($urandom_range(0, 1) == 1) ? len + 1'b1 : len - 1'b1;
                    random_words += 2 + tree_bytes.size();
                end
                FLAW_TRUNCATED: begin
                    repeat ($urandom_range(1, tree_bytes.size() - 1))
                        void'(tree_bytes.pop_back());
                    data_bytes.delete();
                    random_words += 2 + tree_bytes.size();
                end
                FLAW_NOISE: begin
                    tree_bytes.delete();
                    repeat ($urandom_range(2, 14))
                        tree_bytes.push_back(t_octet'($urandom_range(0, 255)));
                    len = ($urandom_range(0, 3) == 0) ? 13'($urandom_range(0, 8191))
                                                      : 13'($urandom_range(0, 24));
                    random_words += 2 + tree_bytes.size();
                end
                default: begin
                    random_words += 2 + tree_bytes.size() + data_bytes.size();
                end
            endcase
            queue_file(pad, len);
        end

        // --- reset, then let the driver and monitor run ---
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (file_words.size() > 0 || i_in_valid)
            @(posedge i_clk);
        while (decoded_words.size() > 0)
            @(posedge i_clk);
        // room for any result word that should not be there
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("sent %0d words in %0d files; checked %0d decoded bytes and %0d error words",
                 words_accepted, files_closed, symbols_out, faults_seen);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/hsd_pkg.sv
hw/rtl/hsd_ram.sv
hw/rtl/huffman_stream_decoder_core.sv
tb/huffman_stream_decoder_core_test.sv
